FILE: hw/rtl/pds_pkg.sv
// Shared types and constants for the PLL divider search block.
// Used by pds_divider, pds_seq and pll_divider_search; depends on nothing.

package pds_pkg;

	localparam int TargetW = 20;
	localparam int RefW    = 16;
	localparam int VcoW    = 20;
	localparam int MW      = 7;
	localparam int NW      = 5;
	localparam int RW      = 3;
	localparam int DivW    = 10;  // (n+2) << r, at most 528
	localparam int NumW    = 30;  // target*div + ref/2 stays below 2^30
	localparam int FreqW   = 24;  // ref*(m+2) stays below 2^24
	localparam int StepW   = 5;

	localparam logic [NW-1:0]    NFirst    = NW'(1);
	localparam logic [NW-1:0]    NLast     = NW'(31);
	localparam logic [RW-1:0]    RLast     = RW'(3);
	localparam logic [NumW-1:0]  QMin      = NumW'(2);    // m = 0
	localparam logic [NumW-1:0]  QMax      = NumW'(129);  // m = 127
	localparam logic [MW-1:0]    DivOffset = MW'(2);
	localparam logic [StepW-1:0] StepsQ    = StepW'(NumW);
	localparam logic [StepW-1:0] StepsFreq = StepW'(FreqW);

	localparam logic [RefW-1:0] RefReset    = RefW'(14318);
	localparam logic [VcoW-1:0] VcoMinReset = VcoW'(180000);
	localparam logic [VcoW-1:0] VcoMaxReset = VcoW'(360000);

	localparam logic [1:0] RegRefClock = 2'd0;
	localparam logic [1:0] RegVcoMin   = 2'd1;
	localparam logic [1:0] RegVcoMax   = 2'd2;

	typedef struct packed {
		logic [TargetW-1:0] target_khz;
		logic [1:0]         clock_select;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         clock_slot;
		logic [MW-1:0]      m_value;
		logic [NW-1:0]      n_value;
		logic [RW-1:0]      r_value;
		logic [TargetW-1:0] freq_error;
	} result_t;

	typedef struct packed {
		logic [RefW-1:0] ref_clock_khz;
		logic [VcoW-1:0] vco_min_khz;
		logic [VcoW-1:0] vco_max_khz;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NumW-1:0]  numer;
		logic [RefW-1:0]  denom;
		logic [StepW-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [NumW-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RSRCH,
		ST_MUL1,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_CHECK,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_ERR,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/pds_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pds_pkg for the request and response structs.

module pds_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  pds_pkg::div_req_t   req,
	output pds_pkg::div_rsp_t   rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [pds_pkg::StepW-1:0]   cnt_q;
	logic [pds_pkg::RefW-1:0]    rem_q;
	logic [pds_pkg::NumW-1:0]    sh_q;
	logic [pds_pkg::RefW-1:0]    den_q;
	logic [pds_pkg::RefW:0]      trial;
	logic [pds_pkg::RefW:0]      rem_n;
	logic                        qbit;

	always_comb begin
		trial = {rem_q, sh_q[pds_pkg::NumW-1]};
		qbit  = (trial >= {1'b0, den_q});
		rem_n = qbit ? (trial - {1'b0, den_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - pds_pkg::StepW'(1);
				if (cnt_q == pds_pkg::StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			sh_q  <= req.numer;
			den_q <= req.denom;
		end else if (busy_q) begin
			rem_q <= rem_n[pds_pkg::RefW-1:0];
			sh_q  <= {sh_q[pds_pkg::NumW-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

FILE: hw/rtl/pds_seq.sv
// Search sequencer: picks r, then walks n = 1..31 through the shared divider.
// Depends on pds_pkg; drives pds_divider through div_req_t / div_rsp_t.

module pds_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  pds_pkg::cfg_t       cfg,
	input  logic                start,
	input  pds_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done,
	output pds_pkg::result_t    result,
	output pds_pkg::div_req_t   div_req,
	input  pds_pkg::div_rsp_t   div_rsp
);

	pds_pkg::state_t state_q, state_d;

	logic [pds_pkg::TargetW-1:0] target_q;
	logic [1:0]                  slot_q;
	logic [pds_pkg::RW-1:0]      r_q;
	logic [pds_pkg::NW-1:0]      n_q;
	logic [pds_pkg::MW-1:0]      m_q;
	logic [pds_pkg::NumW-1:0]    numer_q;
	logic [pds_pkg::NumW-1:0]    q_q;
	logic [pds_pkg::FreqW-1:0]   freq_q;
	logic [pds_pkg::MW-1:0]      best_m_q;
	logic [pds_pkg::NW-1:0]      best_n_q;
	logic [pds_pkg::TargetW-1:0] best_err_q;

	logic [pds_pkg::TargetW+3:0] vco;
	logic                        fits;
	logic [pds_pkg::DivW-1:0]    divv;
	logic [pds_pkg::TargetW-1:0] mul_a;
	logic [pds_pkg::DivW-1:0]    mul_b;
	logic [pds_pkg::NumW-1:0]    prod;
	logic                        q_ok;
	logic [pds_pkg::FreqW-1:0]   tgt_x;
	logic [pds_pkg::FreqW-1:0]   err;

	always_comb begin
		vco  = (pds_pkg::TargetW+4)'(target_q) << r_q;
		fits = ((pds_pkg::TargetW+4)'(cfg.vco_min_khz) <= vco)
			&& (vco < (pds_pkg::TargetW+4)'(cfg.vco_max_khz));
		divv = pds_pkg::DivW'({1'b0, n_q} + 6'd2) << r_q;
		q_ok = (q_q >= pds_pkg::QMin) && (q_q <= pds_pkg::QMax);
		tgt_x = pds_pkg::FreqW'(target_q);
		err  = (tgt_x >= freq_q) ? (tgt_x - freq_q) : (freq_q - tgt_x);
	end

	// one multiplier serves both products
	always_comb begin
		if (state_q == pds_pkg::ST_CHECK) begin
			mul_a = pds_pkg::TargetW'(cfg.ref_clock_khz);
			mul_b = pds_pkg::DivW'(q_q[7:0]);
		end else begin
			mul_a = target_q;
			mul_b = divv;
		end
		prod = pds_pkg::NumW'(mul_a) * pds_pkg::NumW'(mul_b);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pds_pkg::ST_IDLE:      if (start) state_d = pds_pkg::ST_RSRCH;
			pds_pkg::ST_RSRCH: begin
				if (fits || r_q == pds_pkg::RLast) begin
					state_d = (cfg.ref_clock_khz == '0) ? pds_pkg::ST_DONE
						: pds_pkg::ST_MUL1;
				end
			end
			pds_pkg::ST_MUL1:      state_d = pds_pkg::ST_DIV1_GO;
			pds_pkg::ST_DIV1_GO:   state_d = pds_pkg::ST_DIV1_WAIT;
			pds_pkg::ST_DIV1_WAIT: if (div_rsp.done) state_d = pds_pkg::ST_CHECK;
			pds_pkg::ST_CHECK:     state_d = q_ok ? pds_pkg::ST_DIV2_GO : pds_pkg::ST_NEXT;
			pds_pkg::ST_DIV2_GO:   state_d = pds_pkg::ST_DIV2_WAIT;
			pds_pkg::ST_DIV2_WAIT: if (div_rsp.done) state_d = pds_pkg::ST_ERR;
			pds_pkg::ST_ERR:       state_d = pds_pkg::ST_NEXT;
			pds_pkg::ST_NEXT: begin
				state_d = (n_q == pds_pkg::NLast) ? pds_pkg::ST_DONE : pds_pkg::ST_MUL1;
			end
			pds_pkg::ST_DONE:      state_d = pds_pkg::ST_IDLE;
			default:               state_d = pds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = (state_q != pds_pkg::ST_IDLE);
		done          = (state_q == pds_pkg::ST_DONE);
		div_req.start = 1'b0;
		div_req.numer = numer_q;
		div_req.denom = cfg.ref_clock_khz;
		div_req.steps = pds_pkg::StepsQ;
		unique case (state_q)
			pds_pkg::ST_DIV1_GO: div_req.start = 1'b1;
			pds_pkg::ST_DIV2_GO: begin
				div_req.start = 1'b1;
				// align the 24-bit numerator at the top of the shift register
				div_req.numer = {numer_q[pds_pkg::FreqW-1:0],
					(pds_pkg::NumW-pds_pkg::FreqW)'(0)};
				div_req.denom = pds_pkg::RefW'(divv);
				div_req.steps = pds_pkg::StepsFreq;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pds_pkg::ST_IDLE: begin
				if (start) begin
					target_q   <= cmd.target_khz;
					slot_q     <= cmd.clock_select;
					r_q        <= '0;
					n_q        <= pds_pkg::NFirst;
					best_m_q   <= pds_pkg::MW'(1);
					best_n_q   <= pds_pkg::NW'(1);
					best_err_q <= cmd.target_khz;
				end
			end
			pds_pkg::ST_RSRCH: if (!fits) r_q <= r_q + pds_pkg::RW'(1);
			pds_pkg::ST_MUL1: begin
				numer_q <= prod + pds_pkg::NumW'(cfg.ref_clock_khz >> 1);
			end
			pds_pkg::ST_DIV1_WAIT: if (div_rsp.done) q_q <= div_rsp.quot;
			pds_pkg::ST_CHECK: begin
				numer_q <= prod;
				m_q     <= q_q[pds_pkg::MW-1:0] - pds_pkg::DivOffset;
			end
			pds_pkg::ST_DIV2_WAIT: begin
				if (div_rsp.done) freq_q <= div_rsp.quot[pds_pkg::FreqW-1:0];
			end
			pds_pkg::ST_ERR: begin
				// strict compare: ties keep the smaller n
				if (err < pds_pkg::FreqW'(best_err_q)) begin
					best_err_q <= err[pds_pkg::TargetW-1:0];
					best_m_q   <= m_q;
					best_n_q   <= n_q;
				end
			end
			pds_pkg::ST_NEXT: n_q <= n_q + pds_pkg::NW'(1);
			default: ;
		endcase
	end

	assign result.clock_slot = slot_q;
	assign result.m_value    = best_m_q;
	assign result.n_value    = best_n_q;
	assign result.r_value    = r_q;
	assign result.freq_error = best_err_q;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("result strobe not followed by idle");
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not start search");
	a_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.n_value != '0) else $error("n of zero reported");
	a_r_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.r_value <= pds_pkg::RW'(4)) else $error("r beyond 4");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> state_q == pds_pkg::ST_DIV1_GO || state_q == pds_pkg::ST_DIV2_GO)
		else $error("divider started outside a go state");

endmodule

FILE: hw/rtl/pll_divider_search.sv
// Top level of the PLL divider search: configuration registers and wiring.
// Depends on pds_pkg, pds_divider and pds_seq.

// A search starts on a cycle with start high and busy low, and busy stays high
// until the result has been shown. The result appears for exactly one cycle with
// done high; the receiver cannot stall it, so capture it then. Each n in 1..31 is
// tried in turn by the single bit-per-cycle divider, which does both divisions of
// each step (30 and 24 iterations); an n whose quotient is out of range skips the
// second. With a zero reference clock the search ends without walking n.
// Write configuration only while busy is low.

module pll_divider_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pds_pkg::cmd_t              cmd,
	output logic                       busy,
	output logic                       done,
	output pds_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [pds_pkg::VcoW-1:0]   cfg_data
);

	pds_pkg::cfg_t     cfg_q;
	pds_pkg::div_req_t div_req;
	pds_pkg::div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_clock_khz <= pds_pkg::RefReset;
			cfg_q.vco_min_khz   <= pds_pkg::VcoMinReset;
			cfg_q.vco_max_khz   <= pds_pkg::VcoMaxReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pds_pkg::RegRefClock: begin
					cfg_q.ref_clock_khz <= cfg_data[pds_pkg::RefW-1:0];
				end
				pds_pkg::RegVcoMin:   cfg_q.vco_min_khz <= cfg_data;
				pds_pkg::RegVcoMax:   cfg_q.vco_max_khz <= cfg_data;
				default: ;  // drop beats to unused indexes
			endcase
		end
	end

	pds_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	pds_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
